// ===== rtl/rdlh_pkg.sv =====
package rdlh_pkg;

  localparam int COUP_W        = 32;
  localparam int LEN_W         = 6;
  localparam int K_W           = 5;
  localparam int BIN_W         = 5;
  localparam int CNT_W         = 6;
  localparam int HIST_BINS     = 32;
  localparam int K_LIMIT       = 31;
  localparam int DEF_MAX_BONDS = 63;
  localparam int OUT_DATA_W    = 16;

  typedef struct packed {
    logic [COUP_W-1:0] coupling;
    logic [LEN_W-1:0]  length;
  } bond_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic  shift;
    logic  wr;
    bond_t data;
  } cell_ctrl_t;

  // histogram bin of a cluster length: (len - 1) / 2
  function automatic logic [BIN_W-1:0] len_bin(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] t;
    t = len - LEN_W'(1);
    return t[LEN_W-1:1];
  endfunction

endpackage

// ===== rtl/rdlh_cell.sv =====
module rdlh_cell (
  input  logic                clk,
  input  rdlh_pkg::cell_ctrl_t ctrl,
  input  logic                sel,
  input  rdlh_pkg::bond_t     nbr,
  output rdlh_pkg::bond_t     bond
);
  import rdlh_pkg::*;

  // a selected cell takes the broadcast bond on a write; otherwise a shift passes the neighbor down
  always_ff @(posedge clk) begin
    if (ctrl.wr && sel) begin
      bond <= ctrl.data;
    end else if (ctrl.shift) begin
      bond <= nbr;
    end
  end

endmodule

// ===== rtl/rdlh_hist.sv =====
module rdlh_hist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          inc,
  input  logic [rdlh_pkg::BIN_W-1:0]    inc_bin,
  input  logic [rdlh_pkg::BIN_W-1:0]    rd_bin,
  output logic [rdlh_pkg::CNT_W-1:0]    rd_count
);
  import rdlh_pkg::*;

  logic [CNT_W-1:0] cnt [HIST_BINS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < HIST_BINS; i++) begin
      if (rst || clear) begin
        cnt[i] <= '0;
      end else if (inc && (inc_bin == BIN_W'(i))) begin
        cnt[i] <= cnt[i] + CNT_W'(1);
      end
    end
  end

  assign rd_count = cnt[rd_bin];

endmodule

// ===== rtl/ring_decimation_length_histogram_unit.sv =====
// ring decimation length histogram
//
// the ring size is set through the cfg channel (cfg_data = k, ring of 2k+1
// bonds, k clipped to what the cell chain holds). bond couplings arrive on the
// s_axis channel as unsigned 16.16 -log2 values, one transaction per bond, one
// per cycle while s_axis_tready is high. a cfg write offered while loading wins
// over a bond, s_axis_tready drops for that cycle. the transaction that
// completes the ring starts a run: k decimations, each a scan pass that
// rotates the ring once through the head cell while tracking the strongest
// bond and its neighbors, a fix-up state, then a compaction pass that rotates
// the ring again, merges the left neighbor and drops the two removed bonds.
// results then leave on m_axis, bins 0..k, tlast on bin k, one per cycle
// while m_axis_tready is high. a stalled receiver simply holds the current bin;
// no bond and no cfg write is taken until the last bin has gone. reset sets k
// to 31, empties the ring and clears the histogram; a cfg write drops a partly
// loaded ring.
module ring_decimation_length_histogram_unit #(
  parameter int MAX_BONDS = rdlh_pkg::DEF_MAX_BONDS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rdlh_pkg::K_W-1:0]          cfg_data,      // half_count
  // bond input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rdlh_pkg::COUP_W-1:0]       s_axis_tdata,  // log_coupling[31:0]
  // histogram output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rdlh_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // bin_index, bin_count
  output logic                              m_axis_tlast   // last_bin
);
  import rdlh_pkg::*;

  localparam int KCAP_RAW = (MAX_BONDS - 1) / 2;
  localparam int KCAP     = (KCAP_RAW > K_LIMIT) ? K_LIMIT : KCAP_RAW;
  localparam int CELLS    = 2 * KCAP + 1;
  localparam int PW       = $clog2(CELLS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FIX,
    ST_COMPACT,
    ST_FINAL,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [K_W-1:0]   half_count;
  logic [PW-1:0]    load_count;
  logic [PW-1:0]    ring_n;       // ring size at the start of this decimation
  logic [PW-1:0]    live;         // bonds currently in the chain
  logic [PW-1:0]    p;            // ring position now at the head cell
  logic [K_W-1:0]   dec_left;
  logic [K_W-1:0]   b;            // bin being emitted
  logic [COUP_W-1:0] min_c;
  logic [LEN_W-1:0] min_len;
  logic [PW-1:0]    m;
  logic [PW-1:0]    left_idx;
  logic [PW-1:0]    right_idx;
  logic             need_right;
  bond_t            left_b;
  bond_t            right_b;
  bond_t            first_b;
  bond_t            prev_b;

  logic [K_W-1:0]   k_eff;
  logic [PW-1:0]    size_n;
  logic [PW-1:0]    last_pos;
  logic             s_acc;
  logic             m_acc;
  logic             drop;
  logic             new_min;
  bond_t            merged;
  logic [COUP_W:0]  csum;

  cell_ctrl_t       ctrl;
  logic [PW-1:0]    sel_idx;
  logic [CELLS-1:0] cell_sel;
  bond_t            bonds [CELLS];
  bond_t            head;

  logic             hist_clear;
  logic             hist_inc;
  logic [BIN_W-1:0] hist_bin;
  logic [CNT_W-1:0] hist_count;

  // k clipped to the capacity of the chain
  assign k_eff    = (half_count > K_W'(KCAP)) ? K_W'(KCAP) : half_count;
  assign size_n   = PW'({k_eff, 1'b1});
  assign last_pos = ring_n - PW'(1);
  assign head     = bonds[0];

  // a pending cfg write holds off the bond stream for that cycle
  assign s_axis_tready = (state == ST_LOAD) && !cfg_valid;
  assign cfg_ready     = (state == ST_LOAD);
  assign m_axis_tvalid = (state == ST_EMIT);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;

  // merged left neighbor: product of couplings is a saturating sum of -log2
  assign csum = {1'b0, left_b.coupling} + {1'b0, right_b.coupling};
  always_comb begin
    merged.coupling = csum[COUP_W] ? '1 : csum[COUP_W-1:0];
    merged.length   = left_b.length + min_len + right_b.length;
  end

  assign drop    = (p == m) || (p == right_idx);
  assign new_min = (p == '0) || (head.coupling < min_c);

  // chain control: load writes by position, passes rotate through the tail
  always_comb begin
    ctrl    = '0;
    sel_idx = live - PW'(1);
    case (state)
      ST_LOAD: begin
        sel_idx                = load_count;
        ctrl.wr                = s_acc;
        ctrl.data.coupling     = s_axis_tdata;
        ctrl.data.length       = LEN_W'(1);
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        ctrl.wr    = 1'b1;
        ctrl.data  = head;
      end
      ST_COMPACT: begin
        ctrl.shift = 1'b1;
        ctrl.wr    = !drop;
        ctrl.data  = (p == left_idx) ? merged : head;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CELLS; g++) begin : g_cell
      bond_t nbr;
      assign cell_sel[g] = (sel_idx == PW'(g));
      if (g == CELLS - 1) begin : g_end
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = bonds[g+1];
      end
      rdlh_cell u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .sel  (cell_sel[g]),
        .nbr  (nbr),
        .bond (bonds[g])
      );
    end
  endgenerate

  // histogram: cleared when a run starts, bumped once per counted bond
  assign hist_clear = s_acc && (load_count == size_n - PW'(1));
  assign hist_inc   = (state == ST_FIX) || (state == ST_FINAL);
  assign hist_bin   = (state == ST_FINAL) ? len_bin(head.length) : len_bin(min_len);

  rdlh_hist u_hist (
    .clk      (clk),
    .rst      (rst),
    .clear    (hist_clear),
    .inc      (hist_inc),
    .inc_bin  (hist_bin),
    .rd_bin   (b),
    .rd_count (hist_count)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - CNT_W - BIN_W){1'b0}}, hist_count, b};
  assign m_axis_tlast = (b == k_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      half_count <= K_W'(K_LIMIT);
      load_count <= '0;
      ring_n     <= '0;
      live       <= '0;
      p          <= '0;
      dec_left   <= '0;
      b          <= '0;
      need_right <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (cfg_valid && cfg_ready) begin
            half_count <= cfg_data;
            load_count <= '0;
          end else if (s_acc) begin
            if (load_count == size_n - PW'(1)) begin
              load_count <= '0;
              ring_n     <= size_n;
              live       <= size_n;
              dec_left   <= k_eff;
              p          <= '0;
              need_right <= 1'b0;
              state      <= (k_eff == '0) ? ST_FINAL : ST_SCAN;
            end else begin
              load_count <= load_count + PW'(1);
            end
          end
        end

        ST_SCAN: begin
          // one full rotation; strict compare keeps the lowest position on a tie
          prev_b     <= head;
          need_right <= new_min && (p != last_pos);
          if (p == '0) begin
            first_b <= head;
          end
          if (need_right) begin
            right_b <= head;
          end
          if (new_min) begin
            min_c   <= head.coupling;
            min_len <= head.length;
            m       <= p;
            left_b  <= prev_b;
          end
          if (p == last_pos) begin
            p     <= '0;
            state <= ST_FIX;
          end else begin
            p <= p + PW'(1);
          end
        end

        ST_FIX: begin
          // wraparound neighbors come from the ends of the scan
          if (m == '0) begin
            left_b   <= prev_b;
            left_idx <= last_pos;
          end else begin
            left_idx <= m - PW'(1);
          end
          if (m == last_pos) begin
            right_b   <= first_b;
            right_idx <= '0;
          end else begin
            right_idx <= m + PW'(1);
          end
          state <= ST_COMPACT;
        end

        ST_COMPACT: begin
          if (drop) begin
            live <= live - PW'(1);
          end
          if (p == last_pos) begin
            p        <= '0;
            ring_n   <= ring_n - PW'(2);
            dec_left <= dec_left - K_W'(1);
            state    <= (dec_left == K_W'(1)) ? ST_FINAL : ST_SCAN;
          end else begin
            p <= p + PW'(1);
          end
        end

        ST_FINAL: begin
          b     <= '0;
          state <= ST_EMIT;
        end

        ST_EMIT: begin
          if (m_acc) begin
            if (b == k_eff) begin
              state <= ST_LOAD;
            end else begin
              b <= b + K_W'(1);
            end
          end
        end

        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // the scan pass never changes the ring size
  a_scan_size: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (live == ring_n))
    else $error("ring size changed during scan");

  // each compaction removes exactly two bonds
  a_compact_two: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPACT && p == last_pos) |=> (live == ring_n))
    else $error("compaction did not remove two bonds");

  // one bond left when the final count is taken
  a_final_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) |-> (live == PW'(1)))
    else $error("more than one bond left at final count");

  // chain never overfills
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    live <= PW'(CELLS))
    else $error("bond count beyond chain length");

  // the last bin hands the block back to loading
  a_last_return: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (state == ST_LOAD))
    else $error("not back to loading after last bin");

endmodule
